// ===== hdl/gpr_pkg.sv =====
// gpr_pkg: types, register codes and mask helpers for the gpio port block
// no dependencies; used by gpr_ctrl, gpr_dp and gpio_port_registers_with_lock
package gpr_pkg;

  localparam int DataW = 32;
  localparam int PortW = 16;
  localparam int IdxW  = 4;

  // access codes
  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  // register map
  localparam logic [IdxW-1:0] RegMode   = 4'd0;
  localparam logic [IdxW-1:0] RegOtype  = 4'd1;
  localparam logic [IdxW-1:0] RegSpeed  = 4'd2;
  localparam logic [IdxW-1:0] RegPull   = 4'd3;
  localparam logic [IdxW-1:0] RegIn     = 4'd4;
  localparam logic [IdxW-1:0] RegOut    = 4'd5;
  localparam logic [IdxW-1:0] RegSetClr = 4'd6;
  localparam logic [IdxW-1:0] RegLock   = 4'd7;
  localparam logic [IdxW-1:0] RegAfLow  = 4'd8;
  localparam logic [IdxW-1:0] RegAfHigh = 4'd9;

  // lock word layout
  localparam int LockKeyBit = 16;

  // lock key sequence progress
  typedef enum logic [1:0] {
    KEY_IDLE = 2'd0,
    KEY_ONE  = 2'd1,
    KEY_ZERO = 2'd2
  } key_step_t;

  // controller to datapath
  typedef struct packed {
    logic access;   // perform the access and load the result register
  } gpr_cmd_t;

  // lock state seen outside the datapath
  typedef struct packed {
    logic             lock_key;
    logic [PortW-1:0] lock_mask;
  } gpr_status_t;

  // widen each pin bit into a 2-bit field
  function automatic logic [DataW-1:0] spread2(input logic [PortW-1:0] m);
    logic [DataW-1:0] r;
    r = '0;
    for (int i = 0; i < PortW; i++) begin
      r[2*i +: 2] = {2{m[i]}};
    end
    return r;
  endfunction

  // widen each of eight pin bits into a 4-bit field
  function automatic logic [DataW-1:0] spread4(input logic [7:0] m);
    logic [DataW-1:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[4*i +: 4] = {4{m[i]}};
    end
    return r;
  endfunction

  // keep frozen bits, take new data elsewhere within the valid bits
  function automatic logic [DataW-1:0] guarded(input logic [DataW-1:0] old_v,
                                               input logic [DataW-1:0] data,
                                               input logic [DataW-1:0] valid,
                                               input logic [DataW-1:0] frozen);
    return (old_v & frozen) | (data & valid & ~frozen);
  endfunction

endpackage

// ===== hdl/gpr_ctrl.sv =====
// gpr_ctrl: handshake controller for the gpio port block
// depends on gpr_pkg; drives the access command into gpr_dp
module gpr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output gpr_pkg::gpr_cmd_t cmd
);

  typedef enum logic {
    S_IDLE = 1'b0,
    S_FULL = 1'b1
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r     <= S_FULL;
            out_valid_r <= 1'b1;
          end
        end
        S_FULL: begin
          if (!out_stall) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b0;
          end
        end
        default: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign cmd.access = in_valid && (state_r == S_IDLE);

endmodule

// ===== hdl/gpr_dp.sv =====
// gpr_dp: port registers, lock sequencer and result register
// depends on gpr_pkg; driven by the command from gpr_ctrl
module gpr_dp #(
  parameter int PINS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  gpr_pkg::gpr_cmd_t               cmd,
  input  logic                            opcode,
  input  logic [gpr_pkg::IdxW-1:0]        reg_index,
  input  logic [gpr_pkg::DataW-1:0]       write_data,
  input  logic [gpr_pkg::PortW-1:0]       pin_levels,
  output logic [gpr_pkg::DataW-1:0]       read_data,
  output logic [gpr_pkg::PortW-1:0]       drive_levels,
  output logic [gpr_pkg::PortW-1:0]       locked_pins,
  output logic                            lock_active,
  output gpr_pkg::gpr_status_t            status
);

  localparam int DW = gpr_pkg::DataW;
  localparam int PW = gpr_pkg::PortW;
  localparam logic [PW-1:0] PinMask = PW'((33'd1 << PINS) - 33'd1);
  localparam logic [DW-1:0] Valid2  = gpr_pkg::spread2(PinMask);
  localparam logic [DW-1:0] ValidLo = gpr_pkg::spread4(PinMask[7:0]);
  localparam logic [DW-1:0] ValidHi = gpr_pkg::spread4(PinMask[15:8]);

  logic [DW-1:0] mode_r, speed_r, pull_r, aflo_r, afhi_r;
  logic [PW-1:0] otype_r, out_r, lock_mask_r, pend_r;
  logic          lock_key_r;
  gpr_pkg::key_step_t step_r;

  logic [DW-1:0] mode_nxt, speed_nxt, pull_nxt, aflo_nxt, afhi_nxt;
  logic [PW-1:0] otype_nxt, out_nxt, lock_mask_nxt, pend_nxt;
  logic          lock_key_nxt;
  gpr_pkg::key_step_t step_nxt;
  logic [DW-1:0] rd_nxt;

  logic [DW-1:0] rd_r;
  logic [PW-1:0] drive_r, locked_r;
  logic          active_r;

  logic [DW-1:0] frz2, frz_lo, frz_hi;
  logic [PW-1:0] wd_lo, wd_hi, key_m;
  logic          key_bit, wr;

  assign frz2    = gpr_pkg::spread2(lock_mask_r);
  assign frz_lo  = gpr_pkg::spread4(lock_mask_r[7:0]);
  assign frz_hi  = gpr_pkg::spread4(lock_mask_r[15:8]);
  assign wd_lo   = write_data[PW-1:0];
  assign wd_hi   = write_data[DW-1:PW];
  assign key_m   = wd_lo & PinMask;
  assign key_bit = write_data[gpr_pkg::LockKeyBit];
  assign wr      = (opcode == gpr_pkg::OpWrite);

  always_comb begin
    mode_nxt      = mode_r;
    otype_nxt     = otype_r;
    speed_nxt     = speed_r;
    pull_nxt      = pull_r;
    out_nxt       = out_r;
    aflo_nxt      = aflo_r;
    afhi_nxt      = afhi_r;
    lock_mask_nxt = lock_mask_r;
    lock_key_nxt  = lock_key_r;
    step_nxt      = step_r;
    pend_nxt      = pend_r;
    rd_nxt        = '0;
    if (wr) begin
      case (reg_index)
        gpr_pkg::RegMode:  mode_nxt  = gpr_pkg::guarded(mode_r, write_data, Valid2, frz2);
        gpr_pkg::RegOtype: otype_nxt = (otype_r & lock_mask_r) |
                                       (wd_lo & PinMask & ~lock_mask_r);
        gpr_pkg::RegSpeed: speed_nxt = gpr_pkg::guarded(speed_r, write_data, Valid2, frz2);
        gpr_pkg::RegPull:  pull_nxt  = gpr_pkg::guarded(pull_r, write_data, Valid2, frz2);
        gpr_pkg::RegOut:   out_nxt   = wd_lo & PinMask;
        gpr_pkg::RegSetClr: out_nxt  = ((out_r & ~(wd_hi & PinMask)) | wd_lo) & PinMask;
        gpr_pkg::RegLock: begin
          if (!lock_key_r) begin
            if (step_r == gpr_pkg::KEY_ONE && !key_bit && key_m == pend_r) begin
              step_nxt = gpr_pkg::KEY_ZERO;
            end else if (step_r == gpr_pkg::KEY_ZERO && key_bit && key_m == pend_r) begin
              lock_mask_nxt = key_m;
              lock_key_nxt  = 1'b1;
              step_nxt      = gpr_pkg::KEY_IDLE;
            end else if (key_bit) begin
              pend_nxt = key_m;
              step_nxt = gpr_pkg::KEY_ONE;
            end else begin
              step_nxt = gpr_pkg::KEY_IDLE;
            end
          end
        end
        gpr_pkg::RegAfLow:  aflo_nxt = gpr_pkg::guarded(aflo_r, write_data, ValidLo, frz_lo);
        gpr_pkg::RegAfHigh: afhi_nxt = gpr_pkg::guarded(afhi_r, write_data, ValidHi, frz_hi);
        default: ;
      endcase
    end else begin
      case (reg_index)
        gpr_pkg::RegMode:   rd_nxt = mode_r;
        gpr_pkg::RegOtype:  rd_nxt = {{PW{1'b0}}, otype_r};
        gpr_pkg::RegSpeed:  rd_nxt = speed_r;
        gpr_pkg::RegPull:   rd_nxt = pull_r;
        gpr_pkg::RegIn:     rd_nxt = {{PW{1'b0}}, pin_levels & PinMask};
        gpr_pkg::RegOut:    rd_nxt = {{PW{1'b0}}, out_r};
        gpr_pkg::RegLock:   rd_nxt = {{(DW-PW-1){1'b0}}, lock_key_r, lock_mask_r};
        gpr_pkg::RegAfLow:  rd_nxt = aflo_r;
        gpr_pkg::RegAfHigh: rd_nxt = afhi_r;
        default:            rd_nxt = '0;
      endcase
    end
  end

  // architectural registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= '0;
      otype_r     <= '0;
      speed_r     <= '0;
      pull_r      <= '0;
      out_r       <= '0;
      aflo_r      <= '0;
      afhi_r      <= '0;
      lock_mask_r <= '0;
      lock_key_r  <= 1'b0;
      step_r      <= gpr_pkg::KEY_IDLE;
      pend_r      <= '0;
    end else if (cmd.access) begin
      mode_r      <= mode_nxt;
      otype_r     <= otype_nxt;
      speed_r     <= speed_nxt;
      pull_r      <= pull_nxt;
      out_r       <= out_nxt;
      aflo_r      <= aflo_nxt;
      afhi_r      <= afhi_nxt;
      lock_mask_r <= lock_mask_nxt;
      lock_key_r  <= lock_key_nxt;
      step_r      <= step_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.access) begin
      rd_r     <= rd_nxt;
      drive_r  <= out_nxt;
      locked_r <= lock_mask_nxt;
      active_r <= lock_key_nxt;
    end
  end

  assign read_data        = rd_r;
  assign drive_levels     = drive_r;
  assign locked_pins      = locked_r;
  assign lock_active      = active_r;
  assign status.lock_key  = lock_key_r;
  assign status.lock_mask = lock_mask_r;

endmodule

// ===== hdl/gpio_port_registers_with_lock.sv =====
// gpio_port_registers_with_lock: top level of the gpio port register block
// depends on gpr_pkg, gpr_ctrl and gpr_dp
//
// usage
//   input channel: one register access per item (opcode, reg_index,
//   write_data, pin_levels), taken when in_valid is high and in_stall low
//   result channel: one item per access (read_data, drive_levels,
//   locked_pins, lock_active), taken when out_valid is high and out_stall low
//   latency: the access is performed at the accepting edge and its result
//   is presented from the next cycle, held in a single output register
//   occupancy: one access at a time; the single output register must be
//   emptied before the next access is taken
//   stalling: while out_stall is high the result holds and in_stall stays
//   high, so no access is performed and nothing is lost
//   reset: all port registers clear, the lock sequence returns to idle and
//   any frozen pins are released; no result is pending
//   lock: writing the lock word with key 1, key 0, key 1 and one mask freezes
//   mode, type, speed, pull and alternate-function bits of the masked pins
//   until reset
module gpio_port_registers_with_lock #(
  parameter int PINS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic [gpr_pkg::IdxW-1:0]      in_reg_index,
  input  logic [gpr_pkg::DataW-1:0]     in_write_data,
  input  logic [gpr_pkg::PortW-1:0]     in_pin_levels,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gpr_pkg::DataW-1:0]     out_read_data,
  output logic [gpr_pkg::PortW-1:0]     out_drive_levels,
  output logic [gpr_pkg::PortW-1:0]     out_locked_pins,
  output logic                          out_lock_active
);

  localparam logic [gpr_pkg::PortW-1:0] PinMask =
    gpr_pkg::PortW'((33'd1 << PINS) - 33'd1);

  gpr_pkg::gpr_cmd_t    cmd;     // access strobe
  gpr_pkg::gpr_status_t status;  // live lock state

  // handshake and sequencing
  gpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // registers, lock sequencer and result register
  gpr_dp #(
    .PINS (PINS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .opcode       (in_opcode),
    .reg_index    (in_reg_index),
    .write_data   (in_write_data),
    .pin_levels   (in_pin_levels),
    .read_data    (out_read_data),
    .drive_levels (out_drive_levels),
    .locked_pins  (out_locked_pins),
    .lock_active  (out_lock_active),
    .status       (status)
  );

  // an accepted access always yields a pending result next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted access produced no result");

  // no access is taken while a result is still pending
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("access accepted over a pending result");

  // once locked, the lock stays and its mask is frozen
  a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    status.lock_key |=> (status.lock_key && $stable(status.lock_mask)))
    else $error("lock released or mask changed before reset");

  // pins beyond the port width never drive
  a_pin_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_drive_levels & ~PinMask) == '0))
    else $error("output data outside the pin range");

endmodule

// ===== sim/tb.sv =====
// tb: self-checking bench for the gpio port register block with pin lock
// sends register accesses, predicts each result item and compares it per field
// depends on gpr_pkg and gpio_port_registers_with_lock
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gpr_pkg::*;

  localparam int PINS = 16;
  // pins that exist on this port
  localparam logic [PortW-1:0] PIN_MASK = PortW'((32'd1 << PINS) - 32'd1);
  // generous ceiling on run length, far above the slowest correct run
  localparam int LIMIT = 200000;
  // settling time after the last awaited result
  localparam int DRAIN = 10;

  // one result item as the block presents it
  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic [PortW-1:0] drive_levels;
    logic [PortW-1:0] locked_pins;
    logic             lock_active;
  } port_result_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic             in_opcode;
  logic [IdxW-1:0]  in_reg_index;
  logic [DataW-1:0] in_write_data;
  logic [PortW-1:0] in_pin_levels;
  logic             out_valid;
  logic             out_stall;
  logic [DataW-1:0] out_read_data;
  logic [PortW-1:0] out_drive_levels;
  logic [PortW-1:0] out_locked_pins;
  logic             out_lock_active;

  // predicted port state, updated in acceptance order
  logic [DataW-1:0] mode_reg    = '0;
  logic [PortW-1:0] otype_reg   = '0;
  logic [DataW-1:0] speed_reg   = '0;
  logic [DataW-1:0] pull_reg    = '0;
  logic [PortW-1:0] odr_reg     = '0;
  logic [DataW-1:0] afl_reg     = '0;
  logic [DataW-1:0] afh_reg     = '0;
  logic [PortW-1:0] frozen_pins = '0;
  logic             lock_done   = 1'b0;
  key_step_t        key_stage   = KEY_IDLE;
  logic [PortW-1:0] key_mask    = '0;

  port_result_t awaited_results[$];
  int           mismatches   = 0;
  int           results_seen = 0;
  int           cycles       = 0;
  // when set, neither side inserts idle cycles
  bit           idle_off     = 1'b0;

  gpio_port_registers_with_lock #(.PINS(PINS)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_reg_index     (in_reg_index),
    .in_write_data    (in_write_data),
    .in_pin_levels    (in_pin_levels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_drive_levels (out_drive_levels),
    .out_locked_pins  (out_locked_pins),
    .out_lock_active  (out_lock_active)
  );

  // 4 ns clock, first rising edge at 2 ns
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // every pin bit widened into a field of w bits, as many fields as fit
  function automatic logic [DataW-1:0] pin_fields(input logic [PortW-1:0] m, input int w);
    logic [DataW-1:0] r;
    for (int b = 0; b < DataW; b++) begin
      r[b] = m[b / w];
    end
    return r;
  endfunction

  // result of one access, moving the predicted state on
  function automatic port_result_t port_access_result(input logic             op,
                                                      input logic [IdxW-1:0]  idx,
                                                      input logic [DataW-1:0] d,
                                                      input logic [PortW-1:0] pins);
    port_result_t     r;
    logic [DataW-1:0] v2, f2, vlo, flo, vhi, fhi;
    logic [PortW-1:0] m;
    logic             key;
    v2  = pin_fields(PIN_MASK, 2);
    f2  = pin_fields(frozen_pins, 2);
    vlo = pin_fields({8'h00, PIN_MASK[7:0]}, 4);
    flo = pin_fields({8'h00, frozen_pins[7:0]}, 4);
    vhi = pin_fields({8'h00, PIN_MASK[15:8]}, 4);
    fhi = pin_fields({8'h00, frozen_pins[15:8]}, 4);
    key = d[LockKeyBit];
    m   = d[PortW-1:0] & PIN_MASK;
    r   = '0;
    if (op == OpWrite) begin
      case (idx)
        // frozen pins keep their old configuration bits
        RegMode:  mode_reg  = (mode_reg & f2) | (d & v2 & ~f2);
        RegOtype: otype_reg = (otype_reg & frozen_pins) | (m & ~frozen_pins);
        RegSpeed: speed_reg = (speed_reg & f2) | (d & v2 & ~f2);
        RegPull:  pull_reg  = (pull_reg & f2) | (d & v2 & ~f2);
        RegAfLow: afl_reg   = (afl_reg & flo) | (d & vlo & ~flo);
        RegAfHigh: afh_reg  = (afh_reg & fhi) | (d & vhi & ~fhi);
        RegOut:   odr_reg   = m;
        // set beats clear on the same pin
        RegSetClr: odr_reg  = ((odr_reg & ~d[31:16]) | m) & PIN_MASK;
        RegLock: begin
          if (!lock_done) begin
            if (key_stage == KEY_ONE && !key && m == key_mask) begin
              key_stage = KEY_ZERO;
            end else if (key_stage == KEY_ZERO && key && m == key_mask) begin
              frozen_pins = m;
              lock_done   = 1'b1;
              key_stage   = KEY_IDLE;
            end else if (key) begin
              // a broken sequence with key set starts afresh
              key_mask  = m;
              key_stage = KEY_ONE;
            end else begin
              key_stage = KEY_IDLE;
            end
          end
        end
        default: ;
      endcase
    end else begin
      case (idx)
        RegMode:   r.read_data = mode_reg;
        RegOtype:  r.read_data = {16'h0000, otype_reg};
        RegSpeed:  r.read_data = speed_reg;
        RegPull:   r.read_data = pull_reg;
        RegIn:     r.read_data = {16'h0000, pins & PIN_MASK};
        RegOut:    r.read_data = {16'h0000, odr_reg};
        RegLock:   r.read_data = {15'h0000, lock_done, frozen_pins};
        RegAfLow:  r.read_data = afl_reg;
        RegAfHigh: r.read_data = afh_reg;
        default:   r.read_data = '0;
      endcase
    end
    r.drive_levels = odr_reg;
    r.locked_pins  = frozen_pins;
    r.lock_active  = lock_done;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [DataW-1:0] got,
                               input logic [DataW-1:0] want);
    mismatches++;
    if (mismatches <= 50) begin
      $display("result %0d: %s got %h, want %h", results_seen, what, got, want);
    end
  endtask

  // offer one access, wait for it to be taken, then record its prediction
  task automatic issue_access(input logic op, input logic [IdxW-1:0] idx,
                              input logic [DataW-1:0] d, input logic [PortW-1:0] pins);
    if (!idle_off && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_reg_index  <= idx;
    in_write_data <= d;
    in_pin_levels <= pins;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    awaited_results.push_back(port_access_result(op, idx, d, pins));
  endtask

  // all-ones and all-zero words, read-only input data and unmapped indexes
  task automatic test_register_extremes();
    issue_access(OpWrite, RegMode, '1, '0);
    issue_access(OpRead, RegMode, '0, '0);
    issue_access(OpWrite, RegOtype, '1, '1);
    issue_access(OpRead, RegOtype, '0, '0);
    issue_access(OpWrite, RegAfLow, '1, '0);
    issue_access(OpRead, RegAfHigh, '1, '1);
    issue_access(OpWrite, RegIn, '1, '1);
    issue_access(OpRead, RegIn, '0, '1);
    issue_access(OpRead, RegIn, '1, '0);
    issue_access(OpWrite, IdxW'(15), '1, '0);
    issue_access(OpRead, IdxW'(15), '0, '0);
    issue_access(OpRead, IdxW'(10), '0, '1);
  endtask

  // output data and the atomic set/clear word, set winning over clear
  task automatic test_set_reset();
    issue_access(OpWrite, RegOut, 32'hFFFF_00FF, '0);
    issue_access(OpWrite, RegSetClr, 32'hFF00_0F0F, '0);
    issue_access(OpRead, RegSetClr, '0, '0);
    issue_access(OpRead, RegOut, '0, '0);
    issue_access(OpWrite, RegSetClr, 32'hFFFF_0000, '0);
  endtask

  // key sequences that break off, restart or carry stray upper bits
  task automatic test_lock_sequence_breaks();
    issue_access(OpWrite, RegLock, 32'h0001_1234, '0);
    issue_access(OpRead, RegLock, '0, '0);
    issue_access(OpWrite, RegLock, 32'h0000_4321, '0);
    issue_access(OpWrite, RegLock, 32'h0001_1234, '0);
    issue_access(OpWrite, RegLock, 32'h0001_5678, '0);
    issue_access(OpWrite, RegLock, 32'h0000_5678, '0);
    issue_access(OpWrite, RegLock, 32'h0000_5678, '0);
    issue_access(OpWrite, RegLock, 32'h0001_5678, '0);
    issue_access(OpWrite, RegLock, 32'h0000_5678, '0);
    issue_access(OpWrite, RegLock, 32'h0001_9ABC, '0);
    issue_access(OpWrite, RegLock, 32'hFFFE_0001, '0);
  endtask

  // random accesses; before the lock engages, a sequence at its last step
  // is always broken so the port stays unlocked
  task automatic test_random_accesses(input int count, input int quiet_tail);
    logic             op;
    logic [IdxW-1:0]  idx;
    logic [DataW-1:0] d;
    logic [PortW-1:0] pins, m;
    logic             key;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        idle_off = ($urandom_range(0, 4) == 0);
      end
      if (i >= count - quiet_tail) begin
        idle_off = 1'b1;
      end
      op = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 4) == 0) begin
        idx = RegLock;
      end else if ($urandom_range(0, 15) == 0) begin
        idx = IdxW'($urandom_range(10, 15));
      end else begin
        idx = IdxW'($urandom_range(0, 9));
      end
      case ($urandom_range(0, 7))
        0: d = '0;
        1: d = '1;
        default: d = $urandom;
      endcase
      case ($urandom_range(0, 5))
        0: pins = '0;
        1: pins = '1;
        default: pins = PortW'($urandom);
      endcase
      if (op == OpWrite && idx == RegLock && !lock_done) begin
        // mostly reuse the pending mask to walk the key sequence deeper
        key = 1'($urandom_range(0, 1));
        m   = ($urandom_range(0, 2) != 0) ? key_mask : PortW'($urandom);
        if (key_stage == KEY_ZERO && key && (m & PIN_MASK) == key_mask) begin
          m = key_mask ^ (PortW'(1) << $urandom_range(0, PINS - 1));
        end
        d = {d[31:17], key, m};
      end
      issue_access(op, idx, d, pins);
    end
  endtask

  // full key sequence, then the frozen pins must hold against writes
  task automatic test_lock_engage();
    logic [IdxW-1:0]  cfg_regs [6] = '{RegMode, RegOtype, RegSpeed, RegPull,
                                       RegAfLow, RegAfHigh};
    logic [PortW-1:0] m;
    // now and then an empty mask: lock active with nothing frozen
    m = ($urandom_range(0, 7) == 0) ? '0 : PortW'($urandom_range(1, 65535));
    idle_off = 1'b0;
    // back to idle whatever step the random part left behind
    issue_access(OpWrite, RegLock, {16'h0000, ~key_mask}, '0);
    issue_access(OpWrite, RegLock, {15'($urandom), 1'b1, m}, '0);
    issue_access(OpRead, RegLock, '0, '0);
    issue_access(OpWrite, RegLock, {15'($urandom), 1'b0, m}, '0);
    issue_access(OpRead, RegLock, '0, PortW'($urandom));
    issue_access(OpWrite, RegLock, {15'($urandom), 1'b1, m}, '0);
    issue_access(OpRead, RegLock, '0, '0);
    // lock word no longer changes
    issue_access(OpWrite, RegLock, {15'($urandom), 1'b1, ~m}, '0);
    issue_access(OpRead, RegLock, '0, '0);
    foreach (cfg_regs[k]) begin
      issue_access(OpWrite, cfg_regs[k], '1, '0);
      issue_access(OpRead, cfg_regs[k], '0, '0);
      issue_access(OpWrite, cfg_regs[k], '0, '0);
      issue_access(OpRead, cfg_regs[k], '0, '0);
    end
  endtask

  // receiver stalls in random bursts
  initial begin : receiver_stalls
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!idle_off && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // each taken result against the oldest prediction
  always @(posedge clk) begin : result_check
    port_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        note_mismatch("result with nothing awaited", out_read_data, '0);
      end else begin
        want = awaited_results.pop_front();
        if (out_read_data !== want.read_data) begin
          note_mismatch("read_data", out_read_data, want.read_data);
        end
        if (out_drive_levels !== want.drive_levels) begin
          note_mismatch("drive_levels", out_drive_levels, want.drive_levels);
        end
        if (out_locked_pins !== want.locked_pins) begin
          note_mismatch("locked_pins", out_locked_pins, want.locked_pins);
        end
        if (out_lock_active !== want.lock_active) begin
          note_mismatch("lock_active", out_lock_active, want.lock_active);
        end
      end
    end
  end

  // run ceiling
  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("gpio_port_registers_with_lock: mismatch");
      $finish;
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_opcode     <= OpRead;
    in_reg_index  <= RegMode;
    in_write_data <= '0;
    in_pin_levels <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_register_extremes();
    test_set_reset();
    test_lock_sequence_breaks();
    // unlocked port, then locked, with a calm stretch at the very end
    test_random_accesses(900, 0);
    test_lock_engage();
    test_random_accesses(420, 120);

    in_valid <= 1'b0;
    while (awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0) begin
      $display("gpio_port_registers_with_lock: match");
    end else begin
      $display("gpio_port_registers_with_lock: mismatch");
    end
    $finish;
  end

endmodule
